@@ sv/gaps_pkg.sv @@
package gaps_pkg;

  localparam int unsigned MaxColumnsDef = 16;
  localparam int unsigned MaxRowsDef    = 16;

  localparam int unsigned CostW = 20;
  localparam logic [CostW-1:0] CostMax = '1;
  localparam int unsigned CrdW = 8;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_PATH = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TERR_GRASS   = 2'd0,
    TERR_SAND    = 2'd1,
    TERR_MUD     = 2'd2,
    TERR_BLOCKED = 2'd3
  } terrain_e;

  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_STRAIGHT = 3'd2;
  localparam logic [2:0] REG_DIAGONAL = 3'd3;
  localparam logic [2:0] REG_GRASS    = 3'd4;
  localparam logic [2:0] REG_SAND     = 3'd5;
  localparam logic [2:0] REG_MUD      = 3'd6;

  typedef struct packed {
    logic [6:0] cols;
    logic [6:0] rows;
    logic [5:0] straight;
    logic [5:0] diagonal;
    logic [7:0] grass;
    logic [7:0] sand;
    logic [7:0] mud;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] path_length;
    logic [3:0] x;
    logic [3:0] y;
  } res_t;

  function automatic logic [CrdW-1:0] abs_diff(input logic [CrdW-1:0] a,
                                               input logic [CrdW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // octile distance
  function automatic logic [CostW-1:0] heur(input logic [CrdW-1:0] ax,
                                            input logic [CrdW-1:0] ay,
                                            input logic [5:0] dc,
                                            input logic [5:0] sc);
    logic [CrdW-1:0] mn;
    logic [CrdW-1:0] mx;
    logic [13:0] p1;
    logic [13:0] p2;
    logic [14:0] s;
    mn = (ax < ay) ? ax : ay;
    mx = (ax < ay) ? ay : ax;
    p1 = 14'(mn) * 14'(dc);
    p2 = 14'(mx - mn) * 14'(sc);
    s  = 15'(p1) + 15'(p2);
    return CostW'(s);
  endfunction

  function automatic logic [CostW-1:0] sat_add(input logic [CostW-1:0] a,
                                               input logic [CostW-1:0] b);
    logic [CostW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CostW] ? CostMax : s[CostW-1:0];
  endfunction

  function automatic logic [CrdW-1:0] step_x(input logic [2:0] k,
                                             input logic [CrdW-1:0] c);
    case (k)
      3'd0, 3'd1, 3'd2: return c - 1'b1;
      3'd3, 3'd4, 3'd5: return c + 1'b1;
      default:          return c;
    endcase
  endfunction

  function automatic logic [CrdW-1:0] step_y(input logic [2:0] k,
                                             input logic [CrdW-1:0] c);
    case (k)
      3'd1, 3'd4, 3'd6: return c - 1'b1;
      3'd2, 3'd5, 3'd7: return c + 1'b1;
      default:          return c;
    endcase
  endfunction

  function automatic logic step_diag(input logic [2:0] k);
    case (k)
      3'd1, 3'd2, 3'd4, 3'd5: return 1'b1;
      default:                return 1'b0;
    endcase
  endfunction

endpackage

@@ sv/gaps_if.sv @@
interface gaps_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [3:0] cell_x;
  logic [3:0] cell_y;
  logic [1:0] terrain;
  logic [3:0] dest_x;
  logic [3:0] dest_y;
  logic [7:0] path_index;

  modport source (output valid, func, cell_x, cell_y, terrain, dest_x, dest_y, path_index,
                  input ready);
  modport sink (input valid, func, cell_x, cell_y, terrain, dest_x, dest_y, path_index,
                output ready);
endinterface

interface gaps_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [8:0] path_length;
  logic [3:0] out_x;
  logic [3:0] out_y;

  modport source (output valid, status, path_length, out_x, out_y, input ready);
  modport sink (input valid, status, path_length, out_x, out_y, output ready);
endinterface

interface gaps_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/grid_astar_path_search_core.sv @@
// channel | dir | handshake     | word
// cfg_i   | in  | valid/ready   | index, data
// req_i   | in  | valid/ready   | func, cell_x, cell_y, terrain, dest_x, dest_y, path_index
// rsp_o   | out | valid/ready   | status, path_length, out_x, out_y
//
// Search first clears the node memory, then per expanded cell scans the open
// list, picks the best entry, removes it from the list and visits each
// neighbor; a found path is then traced back and stored. After reset the
// terrain memory, 2^(XW+YW) entries (256 by default), is cleared with req_i
// not ready. One output register holds a result while the next word is taken.
module grid_astar_path_search_core #(
  parameter int unsigned MAX_COLUMNS = gaps_pkg::MaxColumnsDef,
  parameter int unsigned MAX_ROWS    = gaps_pkg::MaxRowsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  gaps_cfg_if.sink   cfg_i,
  gaps_req_if.sink   req_i,
  gaps_rsp_if.source rsp_o
);
  import gaps_pkg::*;

  cfg_t cfg;
  res_t res, out_q;
  logic res_valid, res_ready, out_vld_q;

  gaps_cfg #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_cfg (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_i),
    .cfg_o (cfg)
  );

  gaps_engine #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_i      (cfg),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_vld_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.path_length = out_q.path_length;
  assign rsp_o.out_x       = out_q.x;
  assign rsp_o.out_y       = out_q.y;

endmodule

@@ sv/gaps_cfg.sv @@
module gaps_cfg #(
  parameter int unsigned MAX_COLUMNS = gaps_pkg::MaxColumnsDef,
  parameter int unsigned MAX_ROWS    = gaps_pkg::MaxRowsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  gaps_cfg_if.sink       cfg_i,
  output gaps_pkg::cfg_t cfg_o
);
  import gaps_pkg::*;

  logic [4:0] width_q;
  logic [4:0] height_q;
  logic [5:0] straight_q;
  logic [5:0] diagonal_q;
  logic [7:0] grass_q;
  logic [7:0] sand_q;
  logic [7:0] mud_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= 5'd16;
      height_q   <= 5'd16;
      straight_q <= 6'd10;
      diagonal_q <= 6'd14;
      grass_q    <= 8'd16;
      sand_q     <= 8'd24;
      mud_q      <= 8'd80;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_WIDTH:    width_q    <= cfg_i.data[4:0];
        REG_HEIGHT:   height_q   <= cfg_i.data[4:0];
        REG_STRAIGHT: straight_q <= cfg_i.data[5:0];
        REG_DIAGONAL: diagonal_q <= cfg_i.data[5:0];
        REG_GRASS:    grass_q    <= cfg_i.data;
        REG_SAND:     sand_q     <= cfg_i.data;
        REG_MUD:      mud_q      <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.cols     = (32'(width_q) > MAX_COLUMNS) ? 7'(MAX_COLUMNS) : 7'(width_q);
    cfg_o.rows     = (32'(height_q) > MAX_ROWS) ? 7'(MAX_ROWS) : 7'(height_q);
    cfg_o.straight = straight_q;
    cfg_o.diagonal = diagonal_q;
    cfg_o.grass    = grass_q;
    cfg_o.sand     = sand_q;
    cfg_o.mud      = mud_q;
  end

endmodule

@@ sv/gaps_engine.sv @@
module gaps_engine #(
  parameter int unsigned MAX_COLUMNS = gaps_pkg::MaxColumnsDef,
  parameter int unsigned MAX_ROWS    = gaps_pkg::MaxRowsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  gaps_req_if.sink       req_i,
  input  gaps_pkg::cfg_t cfg_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output gaps_pkg::res_t res_o
);
  import gaps_pkg::*;

  localparam int unsigned Cells     = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned XW        = $clog2(MAX_COLUMNS);
  localparam int unsigned YW        = $clog2(MAX_ROWS);
  localparam int unsigned AW        = XW + YW;
  localparam int unsigned NodeDepth = 2 ** AW;
  localparam int unsigned CW        = $clog2(Cells);
  localparam int unsigned ListDepth = 2 ** CW;
  localparam int unsigned LW        = $clog2(Cells + 1);
  localparam int unsigned GW        = CostW + 1;
  localparam logic [GW-1:0] GInf    = {1'b1, {CostW{1'b0}}};

  typedef struct packed {
    logic [GW-1:0] g;
    logic [AW-1:0] pred;
    logic          pvld;
    logic          is_closed;
    logic          is_open;
  } node_t;

  typedef enum logic [16:0] {
    S_TCLR  = 17'd1,
    S_IDLE  = 17'd2,
    S_PRD   = 17'd4,
    S_INIT  = 17'd8,
    S_START = 17'd16,
    S_SCAN  = 17'd32,
    S_PICK  = 17'd64,
    S_SHIFT = 17'd128,
    S_CUR   = 17'd256,
    S_NADDR = 17'd512,
    S_NDATA = 17'd1024,
    S_NUPD  = 17'd2048,
    S_P1RD  = 17'd4096,
    S_P1CHK = 17'd8192,
    S_P2WR  = 17'd16384,
    S_P2NX  = 17'd32768,
    S_RES   = 17'd65536
  } state_e;

  // memories
  logic [1:0]       terr_mem [NodeDepth];
  node_t            node_mem [NodeDepth];
  logic [CostW-1:0] f_mem    [NodeDepth];
  logic [AW-1:0]    list_mem [ListDepth];
  logic [AW-1:0]    path_mem [ListDepth];

  logic             terr_we, node_we, f_we, list_we, path_we;
  logic [AW-1:0]    terr_wa, terr_ra, node_wa, node_ra, f_wa, f_ra;
  logic [CW-1:0]    list_wa, list_ra, path_wa, path_ra;
  logic [1:0]       terr_wd, terr_rd;
  node_t            node_wd, node_rd;
  logic [CostW-1:0] f_wd, f_rd;
  logic [AW-1:0]    list_wd, list_rd, path_wd, path_rd;

  always_ff @(posedge clk_i) begin
    if (terr_we) terr_mem[terr_wa] <= terr_wd;
    terr_rd <= terr_mem[terr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    node_rd <= node_mem[node_ra];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) f_mem[f_wa] <= f_wd;
    f_rd <= f_mem[f_ra];
  end

  always_ff @(posedge clk_i) begin
    if (list_we) list_mem[list_wa] <= list_wd;
    list_rd <= list_mem[list_ra];
  end

  always_ff @(posedge clk_i) begin
    if (path_we) path_mem[path_wa] <= path_wd;
    path_rd <= path_mem[path_ra];
  end

  // registers
  state_e           state_q;
  logic [AW-1:0]    sweep_q, src_q, dst_q;
  logic [LW-1:0]    cnt_q, si_q, idx1_q, idx2_q, best_idx_q, sh_r_q;
  logic             v1_q, v2_q, best_vld_q, sh_pend_q;
  logic [AW-1:0]    cell2_q, best_cell_q, nb_q, pc_q;
  logic [CostW-1:0] best_f_q, g_cur_q, h_q;
  logic [CW-1:0]    sh_wa_q;
  logic [3:0]       k_q;
  logic             nb_diag_q, n_open_q;
  logic [9:0]       step_q;
  logic [GW-1:0]    n_g_q;
  logic [LW-1:0]    plen_q, pi_q, stored_len_q;
  logic [1:0]       res_status_q;
  logic [3:0]       res_x_q, res_y_q;

  // input decode
  logic [AW-1:0]   in_cell, in_dest;
  logic            cell_ok, dest_ok, read_ok, accept;
  assign in_cell = {YW'(req_i.cell_y), XW'(req_i.cell_x)};
  assign in_dest = {YW'(req_i.dest_y), XW'(req_i.dest_x)};
  assign cell_ok = (7'(req_i.cell_x) < cfg_i.cols) && (7'(req_i.cell_y) < cfg_i.rows);
  assign dest_ok = (7'(req_i.dest_x) < cfg_i.cols) && (7'(req_i.dest_y) < cfg_i.rows);
  assign read_ok = (16'(req_i.path_index) < 16'(stored_len_q)) &&
                   (16'(req_i.path_index) < 16'(Cells));
  assign req_i.ready = (state_q == S_IDLE);
  assign accept = req_i.valid && req_i.ready;

  // neighbor and cost terms
  logic [CrdW-1:0]  cur_x, cur_y, tx, ty, sx, sy, nx, ny, nbx, nby;
  logic [AW-1:0]    nb_addr;
  logic             nb_in;
  logic [CostW-1:0] h_src, cand;
  logic [7:0]       pen;
  logic [13:0]      step_prod;

  assign cur_x = CrdW'(best_cell_q[XW-1:0]);
  assign cur_y = CrdW'(best_cell_q[AW-1:XW]);
  assign tx    = CrdW'(dst_q[XW-1:0]);
  assign ty    = CrdW'(dst_q[AW-1:XW]);
  assign sx    = CrdW'(src_q[XW-1:0]);
  assign sy    = CrdW'(src_q[AW-1:XW]);
  assign nbx   = CrdW'(nb_q[XW-1:0]);
  assign nby   = CrdW'(nb_q[AW-1:XW]);
  assign nx    = step_x(k_q[2:0], cur_x);
  assign ny    = step_y(k_q[2:0], cur_y);
  assign nb_in = (nx < CrdW'(cfg_i.cols)) && (ny < CrdW'(cfg_i.rows));
  assign nb_addr = {ny[YW-1:0], nx[XW-1:0]};
  assign h_src = heur(abs_diff(sx, tx), abs_diff(sy, ty), cfg_i.diagonal, cfg_i.straight);
  assign cand  = sat_add(g_cur_q, CostW'(step_q));

  always_comb begin
    case (terrain_e'(terr_rd))
      TERR_GRASS: pen = cfg_i.grass;
      TERR_SAND:  pen = cfg_i.sand;
      TERR_MUD:   pen = cfg_i.mud;
      default:    pen = 8'd0;
    endcase
    step_prod = 14'(nb_diag_q ? cfg_i.diagonal : cfg_i.straight) * 14'(pen);
  end

  // memory port control
  always_comb begin
    terr_we = 1'b0;
    terr_wa = sweep_q;
    terr_wd = TERR_GRASS;
    terr_ra = nb_addr;
    node_we = 1'b0;
    node_wa = nb_q;
    node_wd = node_rd;
    node_ra = nb_addr;
    f_we    = 1'b0;
    f_wa    = nb_q;
    f_wd    = sat_add(cand, h_q);
    f_ra    = list_rd;
    list_we = 1'b0;
    list_wa = CW'(cnt_q);
    list_wd = nb_q;
    list_ra = CW'(si_q);
    path_we = 1'b0;
    path_wa = CW'(plen_q - LW'(1) - pi_q);
    path_wd = pc_q;
    path_ra = CW'(req_i.path_index);
    case (state_q)
      S_TCLR: begin
        terr_we = 1'b1;
      end
      S_IDLE: begin
        if (accept && func_e'(req_i.func) == FUNC_WRITE && cell_ok) begin
          terr_we = 1'b1;
          terr_wa = in_cell;
          terr_wd = req_i.terrain;
        end
      end
      S_INIT: begin
        node_we = 1'b1;
        node_wa = sweep_q;
        node_wd = '{g: GInf, pred: '0, pvld: 1'b0, is_closed: 1'b0, is_open: 1'b0};
      end
      S_START: begin
        node_we = 1'b1;
        node_wa = src_q;
        node_wd = '{g: '0, pred: '0, pvld: 1'b0, is_closed: 1'b0, is_open: 1'b1};
        f_we    = 1'b1;
        f_wa    = src_q;
        f_wd    = h_src;
        list_we = 1'b1;
        list_wa = '0;
        list_wd = src_q;
      end
      S_SHIFT: begin
        list_ra = CW'(sh_r_q);
        list_we = sh_pend_q;
        list_wa = sh_wa_q;
        list_wd = list_rd;
        node_ra = best_cell_q;
      end
      S_CUR: begin
        node_we = 1'b1;
        node_wa = best_cell_q;
        node_wd.is_closed = 1'b1;
        node_wd.is_open   = 1'b0;
      end
      S_NDATA: begin
        if (!node_rd.is_closed && terrain_e'(terr_rd) == TERR_BLOCKED) begin
          node_we = 1'b1;
          node_wd.is_closed = 1'b1;
        end
      end
      S_NUPD: begin
        if ({1'b0, cand} < n_g_q) begin
          node_we = 1'b1;
          node_wd = '{g: {1'b0, cand}, pred: best_cell_q, pvld: 1'b1, is_closed: 1'b0,
                      is_open: n_open_q || (cnt_q < LW'(Cells))};
          f_we    = 1'b1;
          list_we = !n_open_q && (cnt_q < LW'(Cells));
        end
      end
      S_P1RD: begin
        node_ra = pc_q;
      end
      S_P2WR: begin
        path_we = 1'b1;
        node_ra = pc_q;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_TCLR;
      sweep_q      <= '0;
      src_q        <= '0;
      dst_q        <= '0;
      cnt_q        <= '0;
      si_q         <= '0;
      idx1_q       <= '0;
      idx2_q       <= '0;
      best_idx_q   <= '0;
      sh_r_q       <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      best_vld_q   <= 1'b0;
      sh_pend_q    <= 1'b0;
      cell2_q      <= '0;
      best_cell_q  <= '0;
      nb_q         <= '0;
      pc_q         <= '0;
      best_f_q     <= '0;
      g_cur_q      <= '0;
      h_q          <= '0;
      sh_wa_q      <= '0;
      k_q          <= '0;
      nb_diag_q    <= 1'b0;
      n_open_q     <= 1'b0;
      step_q       <= '0;
      n_g_q        <= '0;
      plen_q       <= '0;
      pi_q         <= '0;
      stored_len_q <= '0;
      res_status_q <= ST_OK;
      res_x_q      <= '0;
      res_y_q      <= '0;
    end else begin
      case (state_q)
        S_TCLR: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == {AW{1'b1}}) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            res_x_q      <= '0;
            res_y_q      <= '0;
            res_status_q <= ST_RANGE;
            state_q      <= S_RES;
            case (func_e'(req_i.func))
              FUNC_WRITE: begin
                if (cell_ok) res_status_q <= ST_OK;
              end
              FUNC_SEARCH: begin
                if (cell_ok && dest_ok) begin
                  src_q   <= in_cell;
                  dst_q   <= in_dest;
                  sweep_q <= '0;
                  state_q <= S_INIT;
                end
              end
              FUNC_READ: begin
                if (read_ok) state_q <= S_PRD;
              end
              default: ;
            endcase
          end
        end
        S_PRD: begin
          res_x_q      <= 4'(path_rd[XW-1:0]);
          res_y_q      <= 4'(path_rd[AW-1:XW]);
          res_status_q <= ST_OK;
          state_q      <= S_RES;
        end
        S_INIT: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == {AW{1'b1}}) state_q <= S_START;
        end
        S_START: begin
          cnt_q      <= LW'(1);
          si_q       <= '0;
          v1_q       <= 1'b0;
          v2_q       <= 1'b0;
          best_vld_q <= 1'b0;
          state_q    <= S_SCAN;
        end
        S_SCAN: begin
          v1_q    <= (si_q < cnt_q);
          idx1_q  <= si_q;
          if (si_q < cnt_q) si_q <= si_q + 1'b1;
          v2_q    <= v1_q;
          idx2_q  <= idx1_q;
          cell2_q <= list_rd;
          if (v2_q && (!best_vld_q || f_rd < best_f_q)) begin
            best_vld_q  <= 1'b1;
            best_f_q    <= f_rd;
            best_idx_q  <= idx2_q;
            best_cell_q <= cell2_q;
          end
          if (si_q == cnt_q && !v1_q && !v2_q) begin
            if (best_vld_q) begin
              state_q <= S_PICK;
            end else begin
              stored_len_q <= '0;
              res_status_q <= ST_NO_PATH;
              state_q      <= S_RES;
            end
          end
        end
        S_PICK: begin
          if (best_cell_q == dst_q) begin
            pc_q    <= dst_q;
            plen_q  <= LW'(1);
            state_q <= S_P1RD;
          end else begin
            sh_r_q    <= best_idx_q + 1'b1;
            sh_pend_q <= 1'b0;
            state_q   <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (sh_r_q < cnt_q) begin
            sh_pend_q <= 1'b1;
            sh_wa_q   <= CW'(sh_r_q - LW'(1));
            sh_r_q    <= sh_r_q + 1'b1;
          end else begin
            sh_pend_q <= 1'b0;
            if (!sh_pend_q) begin
              cnt_q   <= cnt_q - 1'b1;
              state_q <= S_CUR;
            end
          end
        end
        S_CUR: begin
          g_cur_q <= node_rd.g[CostW-1:0];
          k_q     <= '0;
          state_q <= S_NADDR;
        end
        S_NADDR: begin
          if (k_q[3]) begin
            si_q       <= '0;
            v1_q       <= 1'b0;
            v2_q       <= 1'b0;
            best_vld_q <= 1'b0;
            state_q    <= S_SCAN;
          end else if (nb_in) begin
            nb_q      <= nb_addr;
            nb_diag_q <= step_diag(k_q[2:0]);
            state_q   <= S_NDATA;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_NDATA: begin
          if (node_rd.is_closed || terrain_e'(terr_rd) == TERR_BLOCKED) begin
            k_q     <= k_q + 1'b1;
            state_q <= S_NADDR;
          end else begin
            step_q   <= step_prod[13:4];
            h_q      <= heur(abs_diff(nbx, tx), abs_diff(nby, ty),
                             cfg_i.diagonal, cfg_i.straight);
            n_g_q    <= node_rd.g;
            n_open_q <= node_rd.is_open;
            state_q  <= S_NUPD;
          end
        end
        S_NUPD: begin
          if ({1'b0, cand} < n_g_q && !n_open_q && cnt_q < LW'(Cells)) begin
            cnt_q <= cnt_q + 1'b1;
          end
          k_q     <= k_q + 1'b1;
          state_q <= S_NADDR;
        end
        S_P1RD: begin
          state_q <= S_P1CHK;
        end
        S_P1CHK: begin
          if (node_rd.pvld && plen_q < LW'(Cells)) begin
            pc_q    <= node_rd.pred;
            plen_q  <= plen_q + 1'b1;
            state_q <= S_P1RD;
          end else begin
            pc_q    <= dst_q;
            pi_q    <= '0;
            state_q <= S_P2WR;
          end
        end
        S_P2WR: begin
          pi_q    <= pi_q + 1'b1;
          state_q <= S_P2NX;
        end
        S_P2NX: begin
          if (pi_q == plen_q) begin
            stored_len_q <= plen_q;
            res_status_q <= ST_OK;
            state_q      <= S_RES;
          end else begin
            if (node_rd.pvld) pc_q <= node_rd.pred;
            state_q <= S_P2WR;
          end
        end
        S_RES: begin
          if (res_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o       = (state_q == S_RES);
  assign res_o.status      = res_status_q;
  assign res_o.path_length = 9'(stored_len_q);
  assign res_o.x           = res_x_q;
  assign res_o.y           = res_y_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LW'(Cells))
    else $error("open list count above capacity");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_len_q <= LW'(Cells))
    else $error("stored path length above capacity");

  a_pick_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PICK |-> best_vld_q)
    else $error("pick without a scanned entry");

  a_res_ret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES && res_ready_i) |=> state_q == S_IDLE)
    else $error("result handed off but not back to idle");

endmodule
